@@ design/gbba_pkg.sv @@
// shared types and constants of the grouped bitmap block allocator
package gbba_pkg;

    localparam int BLK_W     = 17;
    localparam int BPG_W     = 14;
    localparam int GCNT_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GCNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 3'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

    localparam logic [BPG_W-1:0] COUNT_MAX = 14'h3fff;

    typedef struct packed {
        logic       clr_step;
        logic       load_item;
        logic       grp_next;
        logic       div_off;
        logic       scan_init;
        logic       pos_latch;
        logic       mem_rd;
        logic       word_next;
        logic       alloc_wr;
        logic       free_wr;
        logic       emit;
        logic       keep_number;
        logic [1:0] emit_code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic grp_end;
        logic grp_room;
        logic div_done;
        logic below_first;
        logic off_oor;
        logic hit;
        logic scan_end;
        logic bit_used;
    } dp_sts_t;

endpackage

@@ design/gbba_if.sv @@
// request, response and configuration channel interfaces
interface gbba_req_if import gbba_pkg::*;;
    logic             valid;
    logic             ready;
    logic             command;
    logic [BLK_W-1:0] block_to_free;
    modport source (output valid, command, block_to_free, input ready);
    modport sink   (input valid, command, block_to_free, output ready);
endinterface

interface gbba_rsp_if import gbba_pkg::*;;
    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] block_number;
    logic [1:0]       status;
    modport source (output valid, block_number, status, input ready);
    modport sink   (input valid, block_number, status, output ready);
endinterface

interface gbba_cfg_if import gbba_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BLK_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/gbba_ram.sv @@
// generic single write port ram with registered read
module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/gbba_div.sv @@
// restoring divider, one quotient bit per cycle
module gbba_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        shifted = {r_reg, q_reg[NUM_W-1]};
        fits    = shifted >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NUM_W-2:0], fits};
            r_reg <= fits ? DEN_W'(shifted - {1'b0, d_reg}) : shifted[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

@@ design/gbba_datapath.sv @@
// config registers, group counts, bitmap memory, divider and word scan logic
module gbba_datapath import gbba_pkg::*; #(
    parameter int GROUPS    = 8,
    parameter int MAX_BPG   = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [BLK_W-1:0]     cfg_data,
    input  logic [BLK_W-1:0]     item_block,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    output logic [BLK_W-1:0]     res_number,
    output logic [1:0]           res_status
);

    localparam int MAP_BITS  = GROUPS * MAX_BPG;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int POS_W     = $clog2(MAP_BITS);
    localparam int NUM_W     = POS_W > BLK_W ? POS_W : BLK_W;
    localparam int GC_W      = $clog2(GROUPS + 1);
    localparam int GI_W      = GROUPS > 1 ? $clog2(GROUPS) : 1;
    localparam int BASE_W    = $clog2(GROUPS * (2 ** BPG_W) + 2);
    localparam int SUM_W     = (BASE_W > BLK_W ? BASE_W : BLK_W) + 1;
    localparam int IDX_W     = BPG_W + 2;

    // configuration
    logic             first_reg;
    logic [BPG_W-1:0] bpg_reg;
    logic [GCNT_W-1:0] gcnt_reg;
    logic [BLK_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            bpg_reg   <= 14'd8192;
            gcnt_reg  <= 4'd8;
            total_reg <= 17'd65537;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_FIRST: first_reg <= cfg_data[0];
                CFG_BPG:   bpg_reg   <= cfg_data[BPG_W-1:0];
                CFG_GCNT:  gcnt_reg  <= cfg_data[GCNT_W-1:0];
                CFG_TOTAL: total_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    logic [BPG_W-1:0] bpg_eff;
    logic [GC_W-1:0]  ng_eff;

    assign bpg_eff = (bpg_reg == '0) ? BPG_W'(1) :
                     (32'(bpg_reg) > MAX_BPG) ? BPG_W'(MAX_BPG) : bpg_reg;
    assign ng_eff  = (32'(gcnt_reg) > GROUPS) ? GC_W'(GROUPS) : GC_W'(gcnt_reg);

    // working registers
    logic [GC_W-1:0]   g_reg;
    logic [BASE_W-1:0] base_reg;
    logic [POS_W-1:0]  pstart_reg;
    logic [BPG_W-1:0]  limit_reg;
    logic [AW-1:0]     addr_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [BW-1:0]     bit_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [AW-1:0]     clr_reg;
    logic [BPG_W-1:0]  cnt_reg [GROUPS];
    logic [BLK_W-1:0]  num_out_reg;
    logic [1:0]        st_out_reg;
    logic [GI_W-1:0]   gi;

    assign gi = g_reg[GI_W-1:0];

    // divider: block offset over blocks per group, for frees only
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [BPG_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_q;
    logic [BPG_W-1:0] div_r;

    assign div_start = cmd.div_off;
    assign div_num   = NUM_W'(blk_reg - BLK_W'(first_reg));
    assign div_den   = bpg_eff;

    gbba_div #(
        .NUM_W (NUM_W),
        .DEN_W (BPG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q),
        .rem   (div_r)
    );

    // bit position of the block being freed, word and lane by shift and mask
    logic [POS_W-1:0] free_pos;

    assign free_pos = POS_W'(POS_W'(div_q[GC_W-1:0]) * POS_W'(MAX_BPG)) + POS_W'(div_r);

    // bitmap memory
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] rdata;

    // lane qualification and lowest free bit
    logic [WORD_BITS-1:0] avail;
    logic [BW-1:0]        hit_bit;
    logic [IDX_W-1:0]     lane_idx;
    logic [IDX_W-1:0]     end_idx;
    logic [IDX_W-1:0]     hit_idx;
    logic [BLK_W-1:0]     hit_number;

    always_comb
    begin
        hit_bit = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            lane_idx = cur_reg + IDX_W'(j);
            avail[j] = !lane_idx[IDX_W-1] && (lane_idx < {2'b00, limit_reg}) && !rdata[j];
        end
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                hit_bit = BW'(j);
            end
        end
        end_idx    = cur_reg + IDX_W'(WORD_BITS);
        hit_idx    = cur_reg + IDX_W'(hit_bit);
        hit_number = BLK_W'(SUM_W'(base_reg) + SUM_W'(hit_idx));
    end

    always_comb
    begin
        mem_we    = cmd.clr_step | cmd.alloc_wr | cmd.free_wr;
        mem_waddr = cmd.clr_step ? clr_reg : addr_reg;
        if (cmd.clr_step)
        begin
            mem_wdata = '0;
        end
        else if (cmd.alloc_wr)
        begin
            mem_wdata = rdata | (WORD_BITS'(1) << hit_bit);
        end
        else
        begin
            mem_wdata = rdata & ~(WORD_BITS'(1) << bit_reg);
        end
    end

    gbba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.mem_rd),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // scan window limit for the chosen group
    logic [SUM_W-1:0] lim_diff;
    logic [BPG_W-1:0] lim_next;

    always_comb
    begin
        lim_diff = SUM_W'(total_reg) - SUM_W'(base_reg);
        if (lim_diff[SUM_W-1] || lim_diff == '0)
        begin
            lim_next = '0;
        end
        else if (lim_diff > SUM_W'(bpg_eff))
        begin
            lim_next = bpg_eff;
        end
        else
        begin
            lim_next = BPG_W'(lim_diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            for (int k = 0; k < GROUPS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.alloc_wr && cnt_reg[gi] != COUNT_MAX)
            begin
                cnt_reg[gi] <= cnt_reg[gi] + 1'b1;
            end
            if (cmd.free_wr && cnt_reg[gi] != '0)
            begin
                cnt_reg[gi] <= cnt_reg[gi] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            blk_reg    <= item_block;
            g_reg      <= '0;
            base_reg   <= BASE_W'(first_reg);
            pstart_reg <= '0;
        end
        if (cmd.grp_next)
        begin
            g_reg      <= g_reg + 1'b1;
            base_reg   <= base_reg + BASE_W'(bpg_eff);
            pstart_reg <= pstart_reg + POS_W'(MAX_BPG);
        end
        if (cmd.scan_init)
        begin
            limit_reg <= lim_next;
            addr_reg  <= AW'(pstart_reg >> BW);
            cur_reg   <= IDX_W'(0) - IDX_W'(pstart_reg[BW-1:0]);
        end
        if (cmd.pos_latch)
        begin
            g_reg    <= GC_W'(div_q);
            addr_reg <= AW'(free_pos >> BW);
            bit_reg  <= free_pos[BW-1:0];
        end
        if (cmd.word_next)
        begin
            addr_reg <= addr_reg + 1'b1;
            cur_reg  <= cur_reg + IDX_W'(WORD_BITS);
        end
        if (cmd.emit)
        begin
            num_out_reg <= cmd.keep_number ? hit_number : '0;
            st_out_reg  <= cmd.emit_code;
        end
    end

    always_comb
    begin
        sts.clr_last    = clr_reg == AW'(MAP_WORDS - 1);
        sts.grp_end     = g_reg >= ng_eff;
        sts.grp_room    = cnt_reg[gi] < bpg_eff;
        sts.div_done    = div_done;
        sts.below_first = blk_reg < BLK_W'(first_reg);
        sts.off_oor     = div_q >= NUM_W'(ng_eff);
        sts.hit         = |avail;
        sts.scan_end    = !end_idx[IDX_W-1] && (end_idx >= {2'b00, limit_reg});
        sts.bit_used    = rdata[bit_reg];
    end

    assign res_number = num_out_reg;
    assign res_status = st_out_reg;

endmodule

@@ design/gbba_ctrl.sv @@
// request sequencer and response valid
module gbba_ctrl import gbba_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  logic    req_command,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AGRP  = 4'd2;
    localparam logic [3:0] S_ARD   = 4'd3;
    localparam logic [3:0] S_ACHK  = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_FDIV  = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_FBIT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = (req_command == CMD_FREE) ? S_FCHK : S_AGRP;
                end
            end
            S_AGRP:
            begin
                if (sts.grp_end)
                begin
                    if (slot_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = ST_NO_SPACE;
                        state_next    = S_IDLE;
                    end
                end
                else if (sts.grp_room)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_ARD;
                end
                else
                begin
                    cmd.grp_next = 1'b1;
                end
            end
            S_ARD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (sts.hit)
                begin
                    if (slot_free)
                    begin
                        cmd.alloc_wr    = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.keep_number = 1'b1;
                        cmd.emit_code   = ST_DONE;
                        state_next      = S_IDLE;
                    end
                end
                else if (sts.scan_end)
                begin
                    if (slot_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = ST_NO_SPACE;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.word_next = 1'b1;
                    state_next    = S_ARD;
                end
            end
            S_FCHK:
            begin
                if (sts.below_first)
                begin
                    if (slot_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = ST_OUT_OF_RANGE;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_off = 1'b1;
                    state_next  = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.off_oor)
                    begin
                        if (slot_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = ST_OUT_OF_RANGE;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.pos_latch = 1'b1;
                        state_next    = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_FBIT;
            end
            S_FBIT:
            begin
                if (slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.free_wr   = sts.bit_used;
                    cmd.emit_code = sts.bit_used ? ST_DONE : ST_ALREADY_FREE;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || rsp_ready))
        else $error("result loaded over an untaken result");

    a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_wr || cmd.free_wr) |-> (cmd.emit && !(cmd.alloc_wr && cmd.free_wr)))
        else $error("bitmap update without its result");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while one is in flight");

    a_no_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !cmd.emit && !req_ready)
        else $error("activity during clearing pass");

endmodule

@@ design/grouped_bitmap_block_allocator_top.sv @@
// grouped bitmap block allocator, top level
// free: a block below the first data block is answered out of range; else the divider takes N
// steps, N = max(17, clog2(GROUPS*MAX_BLOCKS_PER_GROUP)), then one bitmap word is read and checked
// allocate: full groups are skipped, then bitmap words are read in turn until a free bit is found
// one request in flight; next one taken the cycle after the result loads; a result
// not taken holds the sequencer; reset: async, active low, then a clearing pass over the
// GROUPS*MAX_BLOCKS_PER_GROUP/WORD_BITS bitmap words (2048 by default), no request taken meanwhile
module grouped_bitmap_block_allocator_top import gbba_pkg::*; #(
    parameter int GROUPS               = 8,
    parameter int MAX_BLOCKS_PER_GROUP = 8192,
    parameter int WORD_BITS            = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    gbba_req_if.sink   req,
    gbba_rsp_if.source rsp,
    gbba_cfg_if.sink   cfg
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // config writes are always taken; the user must issue them only while the block is idle, it does not enforce this
    assign cfg.ready = 1'b1;

    // sequencer: walks groups, words and divider steps, owns response valid
    gbba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_command (req.command),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // datapath: config, used counts, bitmap ram, divider, result register
    gbba_datapath #(
        .GROUPS    (GROUPS),
        .MAX_BPG   (MAX_BLOCKS_PER_GROUP),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg.valid),
        .cfg_idx    (cfg.index),
        .cfg_data   (cfg.data),
        .item_block (req.block_to_free),
        .cmd        (cmd),
        .sts        (sts),
        .res_number (rsp.block_number),
        .res_status (rsp.status)
    );

endmodule
